// ===== src/skipgram_hsoftmax_train_step_unit_macros.svh =====
// Assertion macros used by the trainer design file.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SKIPGRAM_HSOFTMAX_TRAIN_STEP_UNIT_MACROS_SVH
`define SKIPGRAM_HSOFTMAX_TRAIN_STEP_UNIT_MACROS_SVH

// Same-cycle implication.
`define SKG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SKG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/skg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skg_pkg
// Types, constants and the sigmoid table builder for the skip-gram trainer.
// ----------------------------------------------------------------------------
package skg_pkg;

    localparam int ROW_W           = 10;
    localparam int ELEM_W          = 7;
    localparam int ADDR_W          = ROW_W + ELEM_W;
    localparam int LAYER_DIMS      = 128;
    localparam int MEM_DEPTH       = 131072;
    localparam int SIGMOID_ENTRIES = 1024;
    localparam int SIG_IDX_W       = 10;

    localparam logic [2:0] OP_WR_WORD = 3'd0;
    localparam logic [2:0] OP_WR_NODE = 3'd1;
    localparam logic [2:0] OP_RD_WORD = 3'd2;
    localparam logic [2:0] OP_RD_NODE = 3'd3;
    localparam logic [2:0] OP_TRAIN   = 3'd4;

    localparam logic [7:0] DIMS_RESET = 8'd128;

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DOT,
        ST_SAT,
        ST_SIG,
        ST_UPD,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef logic [24:0] sig_rom_t [SIGMOID_ENTRIES];

    function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (x < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Shift-and-subtract quotient, evaluated only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'd1);
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // Six-term series of exp(-t/64) in Q2.30, then squared six times.
    function automatic longint unsigned exp_neg_q30(input longint unsigned t);
        longint unsigned y;
        longint unsigned term;
        longint unsigned s;
        longint          sum;
        y    = t >> 6;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int k = 1; k <= 5; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if ((k % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        s = longint'(sum);
        for (int k = 0; k < 6; k++) begin
            s = (s * s + (ONE_Q30 >> 1)) >> 30;
        end
        return s;
    endfunction

    function automatic sig_rom_t build_sig_rom();
        sig_rom_t        rom;
        longint          x;
        longint unsigned t;
        longint unsigned e;
        longint unsigned num;
        longint unsigned den;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            x   = longint'(((64'd12 * longint'(i)) << 30) / SIGMOID_ENTRIES)
                  - longint'(6 * ONE_Q30);
            t   = (x < 0) ? longint'(-x) : longint'(x);
            e   = exp_neg_q30(t);
            num = (x < 0) ? e : ONE_Q30;
            den = ONE_Q30 + e;
            rom[i] = 25'(udiv64((num << 24) + (den >> 1), den));
        end
        return rom;
    endfunction

endpackage

// ===== src/skipgram_hsoftmax_train_step_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skipgram_hsoftmax_train_step_unit
// Skip-gram hierarchical softmax trainer: weight access and one training step.
// ----------------------------------------------------------------------------
// A training step runs a dot pass, the sigmoid, a node update pass and, for the
// last node, a final pass that adds the error accumulator to the word row.
// One item at a time; the next item is taken the cycle after the result loads.
// Each row pass streams one element per cycle through the single-read-port
// weight memories.
// Reset clears control and the error accumulator; weights are undefined until
// written, and no clearing pass runs.
module skipgram_hsoftmax_train_step_unit import skg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               write_enable,
    input  logic [7:0]         write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [9:0]         word_index,
    input  logic [9:0]         node_index,
    input  logic [6:0]         element_index,
    input  logic signed [31:0] weight_value,
    input  logic               code_bit,
    input  logic [24:0]        step_rate,
    input  logic               last_node,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic signed [31:0] dot_product,
    output logic [24:0]        probability,
    output logic signed [25:0] gradient
);

`include "skipgram_hsoftmax_train_step_unit_macros.svh"

    state_t state_reg;
    state_t state_next;

    logic [7:0]          dims_reg;
    logic [2:0]          op_reg;
    logic [ROW_W-1:0]    wrow_reg;
    logic [ROW_W-1:0]    nrow_reg;
    logic                code_reg;
    logic [24:0]         rate_reg;
    logic                last_reg;
    logic [7:0]          n_reg;
    logic [7:0]          cnt_reg;
    logic                v1_reg;
    logic                v2_reg;
    logic [ELEM_W-1:0]   a1_reg;
    logic [ELEM_W-1:0]   a2_reg;
    logic signed [63:0]  prod_reg;
    logic signed [47:0]  acc_reg;
    logic signed [31:0]  dot_reg;
    logic signed [31:0]  rdval_reg;
    logic signed [57:0]  gw_reg;
    logic signed [57:0]  gn_reg;
    logic signed [31:0]  nold_reg;
    logic signed [31:0]  eold_reg;
    logic [LAYER_DIMS-1:0] errv_reg;
    logic                errv_q_reg;

    logic                out_valid_reg;
    logic signed [31:0]  out_read_reg;
    logic signed [31:0]  out_dot_reg;
    logic [24:0]         out_prob_reg;
    logic signed [25:0]  out_grad_reg;

    logic                accept;
    logic                issue;
    logic                phase_end;
    logic                out_load;
    logic                word_we;
    logic                node_we;
    logic                err_we;
    logic [ADDR_W-1:0]   word_raddr;
    logic [ADDR_W-1:0]   node_raddr;
    logic [ADDR_W-1:0]   word_waddr;
    logic [ADDR_W-1:0]   node_waddr;
    logic [31:0]         word_wdata;
    logic [31:0]         node_wdata;
    logic [31:0]         word_q;
    logic [31:0]         node_q;
    logic [31:0]         err_q;
    logic signed [31:0]  err_masked;
    logic signed [31:0]  node_new;
    logic signed [31:0]  err_new;
    logic signed [31:0]  word_new;
    logic                sig_start;
    logic                sig_done;
    logic [24:0]         sig_prob;
    logic signed [25:0]  sig_grad;
    logic [7:0]          dims_c;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign phase_end = (cnt_reg >= n_reg) && !v1_reg && !v2_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign dims_c    = (dims_reg > 8'(LAYER_DIMS)) ? 8'(LAYER_DIMS) : dims_reg;
    assign err_masked = errv_q_reg ? $signed(err_q) : 32'sd0;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode) inside
                        OP_RD_WORD, OP_RD_NODE: state_next = ST_READ;
                        OP_TRAIN:               state_next = ST_DOT;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ:  state_next = ST_DONE;
            ST_DOT:   state_next = phase_end ? ST_SAT : ST_DOT;
            ST_SAT:   state_next = ST_SIG;
            ST_SIG:   state_next = sig_done ? ST_UPD : ST_SIG;
            ST_UPD:
            begin
                if (phase_end)
                begin
                    state_next = last_reg ? ST_APPLY : ST_DONE;
                end
            end
            ST_APPLY: state_next = phase_end ? ST_DONE : ST_APPLY;
            ST_DONE:  state_next = out_load ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory control and pass issue.
    always_comb
    begin
        issue     = 1'b0;
        sig_start = 1'b0;
        word_we   = 1'b0;
        node_we   = 1'b0;
        err_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                word_we = accept && (opcode == OP_WR_WORD);
                node_we = accept && (opcode == OP_WR_NODE);
            end
            ST_DOT:   issue = (cnt_reg < n_reg);
            ST_SAT:   sig_start = 1'b1;
            ST_UPD:
            begin
                issue   = (cnt_reg < n_reg);
                node_we = v2_reg;
                err_we  = v2_reg;
            end
            ST_APPLY:
            begin
                issue   = (cnt_reg < n_reg);
                word_we = v1_reg;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        node_new = sat48(48'(nold_reg) + 48'($signed(gw_reg[57:24])));
        err_new  = sat48(48'(eold_reg) + 48'($signed(gn_reg[57:24])));
        word_new = sat48(48'($signed(word_q)) + 48'(err_masked));
        if (state_reg == ST_IDLE)
        begin
            word_raddr = {word_index, element_index};
            node_raddr = {node_index, element_index};
            word_waddr = {word_index, element_index};
            node_waddr = {node_index, element_index};
            word_wdata = weight_value;
            node_wdata = weight_value;
        end
        else
        begin
            word_raddr = {wrow_reg, cnt_reg[ELEM_W-1:0]};
            node_raddr = {nrow_reg, cnt_reg[ELEM_W-1:0]};
            word_waddr = {wrow_reg, a1_reg};
            node_waddr = {nrow_reg, a2_reg};
            word_wdata = word_new;
            node_wdata = node_new;
        end
    end

    skg_ram #(.DEPTH(MEM_DEPTH), .WIDTH(32), .AW(ADDR_W)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .raddr (word_raddr),
        .rdata (word_q)
    );

    skg_ram #(.DEPTH(MEM_DEPTH), .WIDTH(32), .AW(ADDR_W)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_q)
    );

    skg_ram #(.DEPTH(LAYER_DIMS), .WIDTH(32), .AW(ELEM_W)) u_err_ram (
        .clk   (clk),
        .we    (err_we),
        .waddr (a2_reg),
        .wdata (err_new),
        .raddr (cnt_reg[ELEM_W-1:0]),
        .rdata (err_q)
    );

    skg_sigmoid u_sigmoid (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sig_start),
        .dot   (sat48(acc_reg)),
        .code  (code_reg),
        .rate  (rate_reg),
        .done  (sig_done),
        .prob  (sig_prob),
        .grad  (sig_grad)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dims_reg      <= DIMS_RESET;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            errv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (write_enable)
            begin
                dims_reg <= write_data;
            end
            if (accept || (state_reg == ST_SIG) || ((state_reg == ST_UPD) && phase_end))
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 8'd1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && (state_reg != ST_APPLY);
            if (err_we)
            begin
                errv_reg[a2_reg] <= 1'b1;
            end
            // The accumulator is spent once the word row has taken it.
            if ((state_reg == ST_APPLY) && phase_end)
            begin
                errv_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            wrow_reg <= word_index;
            nrow_reg <= node_index;
            code_reg <= code_bit;
            rate_reg <= step_rate;
            last_reg <= last_node;
            n_reg    <= dims_c;
            acc_reg  <= '0;
        end
        a1_reg     <= cnt_reg[ELEM_W-1:0];
        a2_reg     <= a1_reg;
        errv_q_reg <= errv_reg[cnt_reg[ELEM_W-1:0]];
        if (state_reg == ST_READ)
        begin
            rdval_reg <= (op_reg == OP_RD_WORD) ? $signed(word_q) : $signed(node_q);
        end
        if (v1_reg)
        begin
            prod_reg <= $signed(word_q) * $signed(node_q);
            gw_reg   <= sig_grad * $signed(word_q);
            gn_reg   <= sig_grad * $signed(node_q);
            nold_reg <= $signed(node_q);
            eold_reg <= err_masked;
        end
        if ((state_reg == ST_DOT) && v2_reg)
        begin
            acc_reg <= acc_reg + {{8{prod_reg[63]}}, prod_reg[63:24]};
        end
        if (state_reg == ST_SAT)
        begin
            dot_reg <= sat48(acc_reg);
        end
        if (out_load)
        begin
            out_read_reg <= ((op_reg == OP_RD_WORD) || (op_reg == OP_RD_NODE)) ?
                            rdval_reg : 32'sd0;
            out_dot_reg  <= (op_reg == OP_TRAIN) ? dot_reg : 32'sd0;
            out_prob_reg <= (op_reg == OP_TRAIN) ? sig_prob : 25'd0;
            out_grad_reg <= (op_reg == OP_TRAIN) ? sig_grad : 26'sd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_read_reg;
    assign dot_product = out_dot_reg;
    assign probability = out_prob_reg;
    assign gradient    = out_grad_reg;

    `SKG_ASSERT_IMP(a_sig_done_in_sig, sig_done, state_reg == ST_SIG,
                    "sigmoid done outside wait")
    `SKG_ASSERT_IMP(a_node_we_phase, node_we,
                    (state_reg == ST_IDLE) || (state_reg == ST_UPD),
                    "node write out of phase")
    `SKG_ASSERT_NEXT(a_apply_clears, (state_reg == ST_APPLY) && (state_next == ST_DONE),
                     errv_reg == '0, "error accumulator not cleared")
    `SKG_ASSERT_IMP(a_accept_drained, accept, !v1_reg && !v2_reg,
                    "item accepted with pass in flight")

endmodule

// ===== src/skg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skg_ram
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
module skg_ram #(
    parameter int DEPTH = 131072,
    parameter int WIDTH = 32,
    parameter int AW    = 17
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/skg_sigmoid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skg_sigmoid
// Sigmoid table lookup and gradient, five pipeline stages, one item at a time.
// ----------------------------------------------------------------------------
module skg_sigmoid import skg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dot,
    input  logic               code,
    input  logic [24:0]        rate,
    output logic               done,
    output logic [24:0]        prob,
    output logic signed [25:0] grad
);

    localparam sig_rom_t SIG_ROM = build_sig_rom();
    localparam logic signed [31:0] SPAN_POS = 32'sd100663296;
    localparam logic signed [31:0] SPAN_NEG = -32'sd100663296;
    localparam logic [32:0]        SPAN_U   = 33'd100663296;
    localparam logic [24:0]        ONE_U    = 25'd16777216;
    localparam logic signed [25:0] ONE_S    = 26'sd16777216;

    logic [4:0]           vs_reg;
    logic                 lo_reg;
    logic                 hi_reg;
    logic                 code_reg;
    logic [24:0]          rate_reg;
    logic [11:0]          v_reg;
    logic [SIG_IDX_W-1:0] idx_reg;
    logic [24:0]          rom_reg;
    logic [24:0]          prob_reg;
    logic signed [51:0]   prod_reg;
    logic signed [25:0]   grad_reg;

    logic [32:0]          shifted;
    logic [26:0]          quot;
    logic [24:0]          prob_sel;
    logic [24:0]          rate_c;
    logic signed [25:0]   diff;

    always_comb
    begin
        shifted  = {dot[31], dot} + SPAN_U;
        // Dividing by 3 through the reciprocal is exact for these 12-bit values.
        quot     = v_reg * 15'd21846;
        prob_sel = lo_reg ? 25'd0 : (hi_reg ? ONE_U : rom_reg);
        rate_c   = (rate_reg > ONE_U) ? ONE_U : rate_reg;
        diff     = (code_reg ? 26'sd0 : ONE_S) - $signed({1'b0, prob_sel});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= '0;
        end
        else
        begin
            vs_reg <= {vs_reg[3:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg   <= (dot <= SPAN_NEG);
            hi_reg   <= (dot >= SPAN_POS);
            v_reg    <= shifted[27:16];
            code_reg <= code;
            rate_reg <= rate;
        end
        if (vs_reg[0])
        begin
            idx_reg <= quot[25:16];
        end
        if (vs_reg[1])
        begin
            rom_reg <= SIG_ROM[idx_reg];
        end
        if (vs_reg[2])
        begin
            prob_reg <= prob_sel;
            prod_reg <= diff * $signed({1'b0, rate_c});
        end
        if (vs_reg[3])
        begin
            grad_reg <= prod_reg[49:24];
        end
    end

    assign done = vs_reg[4];
    assign prob = prob_reg;
    assign grad = grad_reg;

endmodule
